// File: rtl/pbba_pkg.sv
// ----------------------------------------------------------------------------
// pbba_pkg
// Types, constants and the saturation helper for the bounding box accumulator.
// ----------------------------------------------------------------------------
package pbba_pkg;

    localparam int COORD_BITS  = 24;
    localparam int RADIUS_BITS = 23;
    localparam int SA_BITS     = 51;
    localparam int AXES        = 3;

    localparam int EXT_W  = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
    localparam int PROD_W = 2 * (COORD_BITS + 1);
    localparam int SUM_W  = PROD_W + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   wide_t;
    typedef logic        [COORD_BITS:0]   extent_t;
    typedef logic signed [EXT_W-1:0]      ext_t;
    typedef logic        [RADIUS_BITS-1:0] radius_t;
    typedef logic        [PROD_W-1:0]     prod_t;
    typedef logic        [SUM_W-1:0]      sum_t;
    typedef logic        [SA_BITS-1:0]    area_t;

    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});

    function automatic coord_t sat_coord(input ext_t v);
        coord_t res;
        if (v > ext_t'(COORD_MAX))
        begin
            res = COORD_MAX;
        end
        else if (v < ext_t'(COORD_MIN))
        begin
            res = COORD_MIN;
        end
        else
        begin
            res = coord_t'(v);
        end
        return res;
    endfunction

endpackage

// File: rtl/primitive_bounding_box_accumulator_core.sv
// ----------------------------------------------------------------------------
// primitive_bounding_box_accumulator_core
// Running axis-aligned bounding box over triangles and spheres, with box
// corners and surface area emitted on the item marked last.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_stall     func, ax..cz, radius, last
//  out      out_valid / out_stall   min_x..max_z, surface_area
//
//  One item accepted per cycle unless a held last item stalls the input;
//  the fold is a combinational compare loop; results go s2, s3, s4, out.
//  Reset empties all stages and returns the running box to its empty value.
//  Items not marked last fold even while the output is stalled; a last item
//  waits in the input register until the result pipeline has room.
// ----------------------------------------------------------------------------
module primitive_bounding_box_accumulator_core
    import pbba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  coord_t              ax,
    input  coord_t              ay,
    input  coord_t              az,
    input  coord_t              bx,
    input  coord_t              by,
    input  coord_t              bz,
    input  coord_t              cx,
    input  coord_t              cy,
    input  coord_t              cz,
    input  radius_t             radius,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output coord_t              min_x,
    output coord_t              min_y,
    output coord_t              min_z,
    output coord_t              max_x,
    output coord_t              max_y,
    output coord_t              max_z,
    output area_t               surface_area
);

    coord_t  in_a [AXES];
    coord_t  in_b [AXES];
    coord_t  in_c [AXES];

    logic    s1_valid_reg;
    logic    s1_sphere_reg;
    logic    s1_last_reg;
    coord_t  s1_a_reg [AXES];
    coord_t  s1_b_reg [AXES];
    coord_t  s1_c_reg [AXES];
    radius_t s1_radius_reg;

    coord_t  run_min_reg [AXES];
    coord_t  run_max_reg [AXES];

    logic    s2_valid_reg;
    coord_t  s2_min_reg [AXES];
    coord_t  s2_max_reg [AXES];

    logic    s3_valid_reg;
    coord_t  s3_min_reg [AXES];
    coord_t  s3_max_reg [AXES];
    extent_t s3_ext_reg [AXES];

    logic    s4_valid_reg;
    coord_t  s4_min_reg [AXES];
    coord_t  s4_max_reg [AXES];
    prod_t   s4_prod_reg [AXES];

    logic    out_valid_reg;
    coord_t  out_min_reg [AXES];
    coord_t  out_max_reg [AXES];
    area_t   out_sa_reg;

    logic    s5_ready;
    logic    s4_ready;
    logic    s3_ready;
    logic    s2_ready;
    logic    s1_take;
    logic    s1_ready;
    logic    in_take;
    logic    fold_last;

    coord_t  item_lo [AXES];
    coord_t  item_hi [AXES];
    coord_t  fold_min [AXES];
    coord_t  fold_max [AXES];
    extent_t ext_next [AXES];
    sum_t    sa_sum;
    sum_t    sa_dbl;

    always_comb
    begin
        in_a[0] = ax;
        in_a[1] = ay;
        in_a[2] = az;
        in_b[0] = bx;
        in_b[1] = by;
        in_b[2] = bz;
        in_c[0] = cx;
        in_c[1] = cy;
        in_c[2] = cz;
    end

    assign s5_ready  = !out_valid_reg || !out_stall;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_take   = s1_valid_reg && (!s1_last_reg || s2_ready);
    assign s1_ready  = !s1_valid_reg || s1_take;
    assign in_take   = in_valid && s1_ready;
    assign in_stall  = !s1_ready;
    assign fold_last = s1_take && s1_last_reg;

    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            if (s1_sphere_reg)
            begin
                item_lo[k] = sat_coord(ext_t'(s1_a_reg[k])
                                       - ext_t'(signed'({1'b0, s1_radius_reg})));
                item_hi[k] = sat_coord(ext_t'(s1_a_reg[k])
                                       + ext_t'(signed'({1'b0, s1_radius_reg})));
            end
            else
            begin
                item_lo[k] = (s1_b_reg[k] < s1_a_reg[k]) ? s1_b_reg[k] : s1_a_reg[k];
                item_lo[k] = (s1_c_reg[k] < item_lo[k])  ? s1_c_reg[k] : item_lo[k];
                item_hi[k] = (s1_b_reg[k] > s1_a_reg[k]) ? s1_b_reg[k] : s1_a_reg[k];
                item_hi[k] = (s1_c_reg[k] > item_hi[k])  ? s1_c_reg[k] : item_hi[k];
            end
            fold_min[k] = (item_lo[k] < run_min_reg[k]) ? item_lo[k] : run_min_reg[k];
            fold_max[k] = (item_hi[k] > run_max_reg[k]) ? item_hi[k] : run_max_reg[k];
            ext_next[k] = extent_t'(wide_t'(s2_max_reg[k]) - wide_t'(s2_min_reg[k]));
        end
        sa_sum = sum_t'(s4_prod_reg[0]) + sum_t'(s4_prod_reg[1]) + sum_t'(s4_prod_reg[2]);
        sa_dbl = {sa_sum[SUM_W-2:0], 1'b0};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < AXES; k++)
            begin
                run_min_reg[k] <= COORD_MAX;
                run_max_reg[k] <= COORD_MIN;
            end
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= fold_last;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                out_valid_reg <= s4_valid_reg;
            end
            // fold the item, or restart the box after a last item
            if (s1_take)
            begin
                for (int k = 0; k < AXES; k++)
                begin
                    run_min_reg[k] <= s1_last_reg ? COORD_MAX : fold_min[k];
                    run_max_reg[k] <= s1_last_reg ? COORD_MIN : fold_max[k];
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sphere_reg <= func;
            s1_last_reg   <= last;
            s1_radius_reg <= radius;
            for (int k = 0; k < AXES; k++)
            begin
                s1_a_reg[k] <= in_a[k];
                s1_b_reg[k] <= in_b[k];
                s1_c_reg[k] <= in_c[k];
            end
        end
        if (fold_last)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                s2_min_reg[k] <= fold_min[k];
                s2_max_reg[k] <= fold_max[k];
            end
        end
        if (s3_ready && s2_valid_reg)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                s3_min_reg[k] <= s2_min_reg[k];
                s3_max_reg[k] <= s2_max_reg[k];
                s3_ext_reg[k] <= ext_next[k];
            end
        end
        if (s4_ready && s3_valid_reg)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                s4_min_reg[k] <= s3_min_reg[k];
                s4_max_reg[k] <= s3_max_reg[k];
            end
            s4_prod_reg[0] <= prod_t'(s3_ext_reg[0]) * prod_t'(s3_ext_reg[1]);
            s4_prod_reg[1] <= prod_t'(s3_ext_reg[0]) * prod_t'(s3_ext_reg[2]);
            s4_prod_reg[2] <= prod_t'(s3_ext_reg[2]) * prod_t'(s3_ext_reg[1]);
        end
        if (s5_ready && s4_valid_reg)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                out_min_reg[k] <= s4_min_reg[k];
                out_max_reg[k] <= s4_max_reg[k];
            end
            out_sa_reg <= SA_BITS'(sa_dbl);
        end
    end

    assign out_valid    = out_valid_reg;
    assign min_x        = out_min_reg[0];
    assign min_y        = out_min_reg[1];
    assign min_z        = out_min_reg[2];
    assign max_x        = out_max_reg[0];
    assign max_y        = out_max_reg[1];
    assign max_z        = out_max_reg[2];
    assign surface_area = out_sa_reg;

`ifndef SYNTHESIS
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (max_x >= min_x) && (max_y >= min_y) && (max_z >= min_z))
        else $error("result box has max below min");

    a_box_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fold_last |=> (run_min_reg[0] == COORD_MAX) && (run_max_reg[0] == COORD_MIN)
                      && (run_min_reg[2] == COORD_MAX) && (run_max_reg[2] == COORD_MIN))
        else $error("running box not restarted after last item");

    a_flat_area: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (max_x == min_x) && (max_y == min_y) |-> surface_area == '0)
        else $error("area of a box flat on two axes is not zero");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_fold_free: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_last_reg |-> !in_stall)
        else $error("item not marked last held back");
`endif

endmodule
